// ===== sv/uart_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared codes and controller/datapath interface types for the UART
// receive/transmit FIFO buffer unit.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  // Request action codes
  localparam logic [1:0] ACT_LINE_BYTE = 2'd0;
  localparam logic [1:0] ACT_SW_READ   = 2'd1;
  localparam logic [1:0] ACT_SW_WRITE  = 2'd2;
  localparam logic [1:0] ACT_TX_READY  = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_TIMEOUT = 3'd3;
  localparam logic [2:0] STAT_DROPPED = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       rx_push;
    logic       rx_pop;
    logic       tx_push;
    logic       tx_pop;
    logic       irq_set;
    logic       irq_clr;
    logic [2:0] status;
  } cmd_t;

  // FIFO status from datapath to controller
  typedef struct packed {
    logic rx_full;
    logic rx_empty;
    logic tx_full;
    logic tx_empty;
  } flags_t;

endpackage

// ===== sv/uart_rb_ctrl.sv =====
// ----------------------------------------------------------------------------
// uart_rb_ctrl
// Handshake state machine and request decoder: turns one accepted request
// into FIFO push/pop and interrupt commands for the datapath.
// ----------------------------------------------------------------------------
module uart_rb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          action,
  input  logic                wait_forever,
  input  uart_rb_pkg::flags_t flags,
  output uart_rb_pkg::cmd_t   cmd
);
  import uart_rb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign out_valid = (state == S_RESP);
  // Hold new requests only while a result waits and is not taken.
  assign in_stall  = (state == S_RESP) && out_stall;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && !in_stall;
    cmd.status = STAT_OK;
    case (action)
      ACT_LINE_BYTE: begin
        if (flags.rx_full) begin
          cmd.status = STAT_DROPPED;
        end else begin
          cmd.rx_push = cmd.load;
        end
      end
      ACT_SW_READ: begin
        if (flags.rx_empty) begin
          cmd.status = wait_forever ? STAT_EMPTY : STAT_TIMEOUT;
        end else begin
          cmd.rx_pop = cmd.load;
        end
      end
      ACT_SW_WRITE: begin
        if (flags.tx_full) begin
          cmd.status = wait_forever ? STAT_FULL : STAT_TIMEOUT;
        end else begin
          cmd.tx_push = cmd.load;
          cmd.irq_set = cmd.load && flags.tx_empty;
        end
      end
      ACT_TX_READY: begin
        if (flags.tx_empty) begin
          cmd.irq_clr = cmd.load;
        end else begin
          cmd.tx_pop = cmd.load;
        end
      end
      default: begin
        cmd.status = STAT_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_stall && !cmd.load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rx_push, cmd.rx_pop, cmd.tx_push, cmd.tx_pop, cmd.irq_clr}))
    else $error("more than one FIFO operation in one cycle");

  a_irq_with_push: assert property (@(posedge clk) disable iff (rst)
    cmd.irq_set |-> cmd.tx_push && flags.tx_empty)
    else $error("interrupt raised without a write into an empty tx FIFO");

  a_result_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("accepted request produced no result");

endmodule

// ===== sv/uart_rb_dp.sv =====
// ----------------------------------------------------------------------------
// uart_rb_dp
// Receive and transmit FIFO storage with wrapping pointers, fill counts,
// transmit interrupt enable and the registered result fields.
// ----------------------------------------------------------------------------
module uart_rb_dp #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  uart_rb_pkg::cmd_t                cmd,
  output uart_rb_pkg::flags_t              flags,
  input  logic [7:0]                       data_byte,
  output logic [2:0]                       status,
  output logic [7:0]                       read_byte,
  output logic                             send_valid,
  output logic [7:0]                       send_byte,
  output logic                             tx_irq_on,
  output logic [$clog2(RX_DEPTH + 1)-1:0]  rx_level,
  output logic [$clog2(TX_DEPTH + 1)-1:0]  tx_level
);
  import uart_rb_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [RX_AW-1:0] rx_wr_pos;
  logic [RX_AW-1:0] rx_rd_pos;
  logic [RX_CW-1:0] rx_fill;
  logic [TX_AW-1:0] tx_wr_pos;
  logic [TX_AW-1:0] tx_rd_pos;
  logic [TX_CW-1:0] tx_fill;
  logic             tx_irq;
  logic [7:0]       rx_data;
  logic [7:0]       tx_data;
  logic             rd_ok;
  logic [2:0]       status_q;

  assign flags.rx_full  = (rx_fill == RX_CW'(RX_DEPTH));
  assign flags.rx_empty = (rx_fill == '0);
  assign flags.tx_full  = (tx_fill == TX_CW'(TX_DEPTH));
  assign flags.tx_empty = (tx_fill == '0);

  // Pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr_pos <= '0;
      rx_rd_pos <= '0;
      rx_fill   <= '0;
      tx_wr_pos <= '0;
      tx_rd_pos <= '0;
      tx_fill   <= '0;
      tx_irq    <= 1'b0;
    end else begin
      if (cmd.rx_push) begin
        rx_wr_pos <= (rx_wr_pos == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_pos + 1'b1;
        rx_fill   <= rx_fill + 1'b1;
      end
      if (cmd.rx_pop) begin
        rx_rd_pos <= (rx_rd_pos == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_pos + 1'b1;
        rx_fill   <= rx_fill - 1'b1;
      end
      if (cmd.tx_push) begin
        tx_wr_pos <= (tx_wr_pos == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_pos + 1'b1;
        tx_fill   <= tx_fill + 1'b1;
      end
      if (cmd.tx_pop) begin
        tx_rd_pos <= (tx_rd_pos == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_pos + 1'b1;
        tx_fill   <= tx_fill - 1'b1;
      end
      if (cmd.irq_set) begin
        tx_irq <= 1'b1;
      end else if (cmd.irq_clr) begin
        tx_irq <= 1'b0;
      end
    end
  end

  // Storage: one write port and one registered read port per FIFO
  always_ff @(posedge clk) begin
    if (cmd.rx_push) rx_mem[rx_wr_pos] <= data_byte;
    if (cmd.rx_pop)  rx_data <= rx_mem[rx_rd_pos];
  end

  always_ff @(posedge clk) begin
    if (cmd.tx_push) tx_mem[tx_wr_pos] <= data_byte;
    if (cmd.tx_pop)  tx_data <= tx_mem[tx_rd_pos];
  end

  // Result fields, held until the next request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_q   <= cmd.status;
      rd_ok      <= cmd.rx_pop;
      send_valid <= cmd.tx_pop;
    end
  end

  assign status    = status_q;
  assign read_byte = rd_ok ? rx_data : 8'h00;
  assign send_byte = send_valid ? tx_data : 8'h00;
  assign tx_irq_on = tx_irq;
  assign rx_level  = rx_fill;
  assign tx_level  = tx_fill;

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= RX_CW'(RX_DEPTH) && tx_fill <= TX_CW'(TX_DEPTH))
    else $error("FIFO fill count beyond depth");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.load) |-> $stable(rx_fill) && $stable(tx_fill))
    else $error("fill count moved without a request");

  a_irq_rise: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(tx_irq) |-> $past(cmd.tx_push) && $past(tx_fill) == '0)
    else $error("tx interrupt rose without a write into an empty FIFO");

endmodule

// ===== sv/uart_rx_tx_ring_buffers_unit.sv =====
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the read port
//   of each FIFO memory is registered.
// A request is held off only while a finished result is stalled.
// Reset (rst, synchronous): pointers, fill counts and the tx interrupt enable
//   clear at once; FIFO storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_unit
// UART receive and transmit byte FIFOs with software read/write, line byte
// capture and transmitter-ready service, plus the tx interrupt enable.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_unit #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [7:0]                       data_byte,
  input  logic                             wait_forever,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [7:0]                       read_byte,
  output logic                             send_valid,
  output logic [7:0]                       send_byte,
  output logic                             tx_irq_on,
  output logic [$clog2(RX_DEPTH + 1)-1:0]  rx_level,
  output logic [$clog2(TX_DEPTH + 1)-1:0]  tx_level
);
  import uart_rb_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // Controller: accept a request, decode it against the FIFO flags and
  // present the result until the far side takes it.
  uart_rb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .wait_forever (wait_forever),
    .flags        (flags),
    .cmd          (cmd)
  );

  // Datapath: FIFO memories, pointers, counts and registered result fields.
  uart_rb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .flags      (flags),
    .data_byte  (data_byte),
    .status     (status),
    .read_byte  (read_byte),
    .send_valid (send_valid),
    .send_byte  (send_byte),
    .tx_irq_on  (tx_irq_on),
    .rx_level   (rx_level),
    .tx_level   (tx_level)
  );

endmodule

// ===== tb/tb_uart_rx_tx_ring_buffers_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_rx_tx_ring_buffers_unit
// Self-checking bench for the UART receive/transmit FIFO unit. Requests go in
// over a valid/stall channel. A request-level model of both FIFOs and the tx interrupt
// enable predicts every result, and each result is checked field by field in
// order. The run covers directed corner cases, overflow and underflow of both
// FIFOs, long output back-pressure, and biased random request bursts.
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers_unit;
  import uart_rb_pkg::*;

  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int LVL_W    = $clog2(RX_DEPTH + 1);

  // One predicted result, in the order the unit reports its fields
  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       read_byte;
    logic             send_valid;
    logic [7:0]       send_byte;
    logic             tx_irq_on;
    logic [LVL_W-1:0] rx_level;
    logic [LVL_W-1:0] tx_level;
  } fifo_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       action;
  logic [7:0]       data_byte;
  logic             wait_forever;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       status;
  logic [7:0]       read_byte;
  logic             send_valid;
  logic [7:0]       send_byte;
  logic             tx_irq_on;
  logic [LVL_W-1:0] rx_level;
  logic [LVL_W-1:0] tx_level;

  // Model of the two FIFOs and the interrupt enable
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  int         rx_wr, rx_rd, rx_used;
  int         tx_wr, tx_rd, tx_used;
  logic       irq_en;

  fifo_result_t pending_results [$];

  // Knobs for the request driver and the result monitor
  bit sender_idle   = 1'b0;
  bit receiver_idle = 1'b0;
  int hold_len      = 0;
  int fail_count    = 0;

  int act_seen  [4];
  int stat_seen [5];

  logic [1:0] action_list [4] = '{ACT_LINE_BYTE, ACT_SW_READ, ACT_SW_WRITE, ACT_TX_READY};

  uart_rx_tx_ring_buffers_unit #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .data_byte    (data_byte),
    .wait_forever (wait_forever),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .read_byte    (read_byte),
    .send_valid   (send_valid),
    .send_byte    (send_byte),
    .tx_irq_on    (tx_irq_on),
    .rx_level     (rx_level),
    .tx_level     (tx_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the FIFO model and return the result it produces.
  function automatic fifo_result_t uart_fifo_step(input logic [1:0] act,
                                                  input logic [7:0] dat,
                                                  input logic wf);
    fifo_result_t r;
    r = '0;
    case (act)
      ACT_LINE_BYTE: begin
        // Drop the line byte and report it as dropped when the receive FIFO is full
        if (rx_used < RX_DEPTH) begin
          rx_mem[rx_wr] = dat;
          rx_wr         = (rx_wr == RX_DEPTH - 1) ? 0 : rx_wr + 1;
          rx_used++;
        end else begin
          r.status = STAT_DROPPED;
        end
      end
      ACT_SW_READ: begin
        if (rx_used == 0) begin
          r.status = wf ? STAT_EMPTY : STAT_TIMEOUT;
        end else begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd       = (rx_rd == RX_DEPTH - 1) ? 0 : rx_rd + 1;
          rx_used--;
        end
      end
      ACT_SW_WRITE: begin
        if (tx_used >= TX_DEPTH) begin
          r.status = wf ? STAT_FULL : STAT_TIMEOUT;
        end else begin
          // Writing into an empty transmit FIFO arms the interrupt
          if (tx_used == 0) irq_en = 1'b1;
          tx_mem[tx_wr] = dat;
          tx_wr         = (tx_wr == TX_DEPTH - 1) ? 0 : tx_wr + 1;
          tx_used++;
        end
      end
      default: begin
        // Transmitter ready: pop a byte, or disarm the interrupt when empty
        if (tx_used == 0) begin
          irq_en = 1'b0;
        end else begin
          r.send_valid = 1'b1;
          r.send_byte  = tx_mem[tx_rd];
          tx_rd        = (tx_rd == TX_DEPTH - 1) ? 0 : tx_rd + 1;
          tx_used--;
        end
      end
    endcase
    r.tx_irq_on = irq_en;
    r.rx_level  = LVL_W'(rx_used);
    r.tx_level  = LVL_W'(tx_used);
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Offer one request, hold it until accepted, then log its prediction.
  task automatic send_request(input logic [1:0] act, input logic [7:0] dat, input logic wf);
    int gap;
    in_valid     <= 1'b1;
    action       <= act;
    data_byte    <= dat;
    wait_forever <= wf;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(uart_fifo_step(act, dat, wf));
    act_seen[act]++;
    if (sender_idle && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [1:0] act);
    send_request(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Pause the request side until every predicted result has been checked.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
      pending_results.delete();
    end
  endtask

  // Corner cases: empty reads both ways, interrupt arm/hold/disarm, byte extremes
  task automatic test_directed();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_request(ACT_SW_READ,   8'h00, 1'b1);
    send_request(ACT_SW_READ,   8'hFF, 1'b0);
    send_request(ACT_TX_READY,  8'hFF, 1'b1);
    send_request(ACT_SW_WRITE,  8'h00, 1'b0);
    send_request(ACT_SW_WRITE,  8'hFF, 1'b1);
    send_request(ACT_TX_READY,  8'h5A, 1'b0);
    // Last byte leaves, interrupt must stay armed
    send_request(ACT_TX_READY,  8'h00, 1'b0);
    send_request(ACT_TX_READY,  8'hA5, 1'b1);
    send_request(ACT_LINE_BYTE, 8'h00, 1'b0);
    send_request(ACT_LINE_BYTE, 8'hFF, 1'b1);
    send_request(ACT_LINE_BYTE, 8'h5A, 1'b0);
    send_request(ACT_SW_READ,   8'hFF, 1'b0);
    send_request(ACT_SW_READ,   8'h00, 1'b1);
    send_request(ACT_SW_READ,   8'hFF, 1'b1);
    send_request(ACT_SW_READ,   8'hFF, 1'b1);
    send_request(ACT_SW_WRITE,  8'hA5, 1'b0);
    send_request(ACT_TX_READY,  8'hFF, 1'b1);
    send_request(ACT_TX_READY,  8'h00, 1'b0);
    wait_drained();
  endtask

  // Fill the receive FIFO past full so bytes get dropped, then read it dry
  task automatic test_rx_overflow();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (RX_DEPTH + 3) send_random(ACT_LINE_BYTE);
    repeat (RX_DEPTH + 2) send_random(ACT_SW_READ);
    wait_drained();
  endtask

  // Fill the transmit FIFO past full, then let the transmitter drain it
  task automatic test_tx_overflow();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (TX_DEPTH + 3) send_random(ACT_SW_WRITE);
    repeat (TX_DEPTH + 2) send_random(ACT_TX_READY);
    wait_drained();
  endtask

  // Hold results off for a long stretch while requests keep coming
  task automatic test_backpressure();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_len      = 60;
    repeat (40) send_random(action_list[$urandom_range(0, 3)]);
    wait_drained();
  endtask

  // Bursts that lean toward one action push the FIFOs to full and to empty
  task automatic test_random_bursts(input int n_items);
    int         done;
    int         burst;
    int         bias;
    logic [1:0] act;
    done = 0;
    while (done < n_items) begin
      burst         = $urandom_range(10, 40);
      bias          = $urandom_range(0, 4);
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        if (done < n_items) begin
          if (bias < 4 && $urandom_range(0, 9) < 7) act = action_list[bias];
          else act = action_list[$urandom_range(0, 3)];
          send_random(act);
          done++;
        end
      end
    end
    wait_drained();
  endtask

  // Result monitor: check each accepted result, then pick next cycle's stall.
  initial begin : result_monitor
    int           stall_left;
    fifo_result_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no request pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status",     8'(want.status),     8'(status));
          check_field("read_byte",  want.read_byte,      read_byte);
          check_field("send_valid", 8'(want.send_valid), 8'(send_valid));
          check_field("send_byte",  want.send_byte,      send_byte);
          check_field("tx_irq_on",  8'(want.tx_irq_on),  8'(tx_irq_on));
          check_field("rx_level",   8'(want.rx_level),   8'(rx_level));
          check_field("tx_level",   8'(want.tx_level),   8'(tx_level));
          if (status <= STAT_DROPPED) stat_seen[status]++;
        end
      end
      // Long hold first, then any random stall in progress, then maybe a new one
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : main_seq
    rx_wr   = 0;
    rx_rd   = 0;
    rx_used = 0;
    tx_wr   = 0;
    tx_rd   = 0;
    tx_used = 0;
    irq_en  = 1'b0;
    // Drive every input to a known value before the first edge
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_LINE_BYTE;
    data_byte    <= 8'h00;
    wait_forever <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_rx_overflow();
    test_tx_overflow();
    test_backpressure();
    test_random_bursts(770);

    // Let the pipeline settle and catch any stray result
    repeat (10) @(posedge clk);
    $display("Covered %0d requests: line %0d, read %0d, write %0d, tx ready %0d",
             act_seen[ACT_LINE_BYTE] + act_seen[ACT_SW_READ] + act_seen[ACT_SW_WRITE]
             + act_seen[ACT_TX_READY], act_seen[ACT_LINE_BYTE], act_seen[ACT_SW_READ],
             act_seen[ACT_SW_WRITE], act_seen[ACT_TX_READY]);
    $display("Statuses: ok %0d, empty %0d, full %0d, timeout %0d, dropped %0d",
             stat_seen[STAT_OK], stat_seen[STAT_EMPTY], stat_seen[STAT_FULL],
             stat_seen[STAT_TIMEOUT], stat_seen[STAT_DROPPED]);
    if (fail_count == 0) begin
      $display("uart_rx_tx_ring_buffers_unit: match");
    end else begin
      $display("uart_rx_tx_ring_buffers_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("uart_rx_tx_ring_buffers_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/uart_rb_pkg.sv
sv/uart_rb_ctrl.sv
sv/uart_rb_dp.sv
sv/uart_rx_tx_ring_buffers_unit.sv
tb/tb_uart_rx_tx_ring_buffers_unit.sv
